/* rtl/rtpjh_pkg.sv */
// Shared types, constants and constant tables of the JPEG header generator.
package rtpjh_pkg;

	localparam int QUANT_ENTRIES = 64;
	localparam int POS_W         = 10;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int DIV_NUM_W     = 20;
	localparam int DIV_DEN_W     = 7;
	localparam int DIV_CNT_W     = 5;
	localparam int SCALE_W       = 13;
	localparam int BASE_W        = 7;
	localparam int QIDX_W        = 6;
	localparam int RND_PROD_W    = 40;
	localparam int RND_SHIFT     = 26;

	localparam logic [CFG_IDX_W-1:0] REG_QUALITY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_CHROMA = 3'd5;

	localparam logic [7:0] QUALITY_RESET = 8'd50;
	localparam logic [19:0] SCALE_NUM    = 20'd5000;
	// ceil(2^26 / 100): exact floor division by 100 for numerators below 1864135
	localparam logic [DIV_NUM_W-1:0] RND_MUL = 20'd671089;

	typedef struct packed {
		logic [7:0]  quality;
		logic        frame_type;
		logic [7:0]  width_blocks;
		logic [7:0]  height_blocks;
		logic [15:0] restart_interval;
		logic        separate_chroma_table;
	} cfg_t;

	typedef struct packed {
		logic              is_quant;
		logic              chroma;
		logic [QIDX_W-1:0] qidx;
		logic [7:0]        value;
	} seg_t;

	localparam logic [BASE_W-1:0] BASE_LUMA [0:QUANT_ENTRIES-1] = '{
		7'd16, 7'd11, 7'd12, 7'd14, 7'd12, 7'd10, 7'd16, 7'd14,
		7'd13, 7'd14, 7'd18, 7'd17, 7'd16, 7'd19, 7'd24, 7'd40,
		7'd26, 7'd24, 7'd22, 7'd22, 7'd24, 7'd49, 7'd35, 7'd37,
		7'd29, 7'd40, 7'd58, 7'd51, 7'd61, 7'd60, 7'd57, 7'd51,
		7'd56, 7'd55, 7'd64, 7'd72, 7'd92, 7'd78, 7'd64, 7'd68,
		7'd87, 7'd69, 7'd55, 7'd56, 7'd80, 7'd109, 7'd81, 7'd87,
		7'd95, 7'd98, 7'd103, 7'd104, 7'd103, 7'd62, 7'd77, 7'd113,
		7'd121, 7'd112, 7'd100, 7'd120, 7'd92, 7'd101, 7'd103, 7'd99
	};

	localparam logic [BASE_W-1:0] BASE_CHROMA [0:QUANT_ENTRIES-1] = '{
		7'd17, 7'd18, 7'd18, 7'd24, 7'd21, 7'd24, 7'd47, 7'd26,
		7'd26, 7'd47, 7'd99, 7'd66, 7'd56, 7'd66, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
	};

	localparam logic [7:0] CODE_COUNTS [0:63] = '{
		8'h00, 8'h01, 8'h05, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h02, 8'h01, 8'h03, 8'h03, 8'h02, 8'h04, 8'h03,
		8'h05, 8'h05, 8'h04, 8'h04, 8'h00, 8'h00, 8'h01, 8'h7d,
		8'h00, 8'h03, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h02, 8'h01, 8'h02, 8'h04, 8'h04, 8'h03, 8'h04,
		8'h07, 8'h05, 8'h04, 8'h04, 8'h00, 8'h01, 8'h02, 8'h77
	};

	localparam logic [7:0] AC_SYMS_LUMA [0:161] = '{
		8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41, 8'h06,
		8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
		8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24, 8'h33, 8'h62, 8'h72,
		8'h82, 8'h09, 8'h0a, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
		8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44, 8'h45,
		8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
		8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75,
		8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
		8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3,
		8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
		8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9,
		8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
		8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf1, 8'hf2, 8'hf3, 8'hf4,
		8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
	};

	localparam logic [7:0] AC_SYMS_CHROMA [0:161] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21, 8'h31, 8'h06, 8'h12, 8'h41,
		8'h51, 8'h07, 8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
		8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0, 8'h15, 8'h62, 8'h72, 8'hd1,
		8'h0a, 8'h16, 8'h24, 8'h34, 8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
		8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44,
		8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
		8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74,
		8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
		8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
		8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
		8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
		8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf2, 8'hf3, 8'hf4,
		8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
	};

	localparam logic [7:0] SOS_BYTES [0:13] = '{
		8'hff, 8'hda, 8'h00, 8'h0c, 8'h03, 8'h00, 8'h00,
		8'h01, 8'h11, 8'h02, 8'h11, 8'h00, 8'h3f, 8'h00
	};

	function automatic logic [POS_W-1:0] hdr_len(input cfg_t cfg);
		logic [POS_W-1:0] len;
		len = cfg.separate_chroma_table ? 10'd605 : 10'd536;
		if (cfg.restart_interval != 16'd0) begin
			len = len + 10'd6;
		end
		return len;
	endfunction

endpackage

/* rtl/rtpjh_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module rtpjh_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [rtpjh_pkg::DIV_NUM_W-1:0]     num,
	input  logic [rtpjh_pkg::DIV_DEN_W-1:0]     den,
	output logic                                done,
	output logic [rtpjh_pkg::DIV_NUM_W-1:0]     quot
);

	logic [rtpjh_pkg::DIV_NUM_W-1:0] quo_q;
	logic [rtpjh_pkg::DIV_DEN_W-1:0] rem_q;
	logic [rtpjh_pkg::DIV_DEN_W-1:0] den_q;
	logic [rtpjh_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [rtpjh_pkg::DIV_DEN_W:0]   trial;
	logic                            fits;
	logic [rtpjh_pkg::DIV_DEN_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[rtpjh_pkg::DIV_NUM_W-1]};
		fits    = (trial >= {1'b0, den_q});
		rem_nxt = fits ? rtpjh_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
		               : trial[rtpjh_pkg::DIV_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= rtpjh_pkg::DIV_CNT_W'(rtpjh_pkg::DIV_NUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[rtpjh_pkg::DIV_NUM_W-2:0], fits};
				rem_q <= rem_nxt;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* rtl/rtpjh_seg.sv */
// Header layout decoder: maps a byte position to a fixed byte or a quantiser entry.
module rtpjh_seg (
	input  logic [rtpjh_pkg::POS_W-1:0] pos,
	input  rtpjh_pkg::cfg_t             cfg,
	output rtpjh_pkg::seg_t             seg
);

	logic                       dri;
	logic [rtpjh_pkg::POS_W-1:0] qend;
	logic [rtpjh_pkg::POS_W-1:0] sof_start;
	logic [rtpjh_pkg::POS_W-1:0] dht_start;
	logic [rtpjh_pkg::POS_W-1:0] sos_start;
	logic [rtpjh_pkg::POS_W-1:0] dq;
	logic [rtpjh_pkg::POS_W-1:0] dq_off;
	logic                       dq_tab;
	logic [rtpjh_pkg::POS_W-1:0] r;
	logic [rtpjh_pkg::POS_W-1:0] s;
	logic [rtpjh_pkg::POS_W-1:0] h;
	logic [rtpjh_pkg::POS_W-1:0] e;
	logic [rtpjh_pkg::POS_W-1:0] o;
	logic [1:0]                 t;
	logic                       ac;
	logic [7:0]                 sym_idx;
	logic [10:0]                hpx;
	logic [10:0]                wpx;
	logic [7:0]                 qsel;

	always_comb begin
		seg       = '0;
		dri       = (cfg.restart_interval != 16'd0);
		qend      = cfg.separate_chroma_table ? 10'd140 : 10'd71;
		sof_start = qend + (dri ? 10'd6 : 10'd0);
		dht_start = sof_start + 10'd19;
		sos_start = dht_start + 10'd432;
		dq        = pos - 10'd2;
		dq_tab    = (dq >= 10'd69);
		dq_off    = dq_tab ? dq - 10'd69 : dq;
		r         = pos - qend;
		s         = pos - sof_start;
		h         = pos - dht_start;
		e         = pos - sos_start;
		hpx       = {cfg.height_blocks, 3'b000};
		wpx       = {cfg.width_blocks, 3'b000};
		qsel      = {7'd0, cfg.separate_chroma_table};
		if (h < 10'd33) begin
			t = 2'd0;
			o = h;
		end else if (h < 10'd216) begin
			t = 2'd1;
			o = h - 10'd33;
		end else if (h < 10'd249) begin
			t = 2'd2;
			o = h - 10'd216;
		end else begin
			t = 2'd3;
			o = h - 10'd249;
		end
		ac      = t[0];
		sym_idx = 8'(o - 10'd21);

		if (pos < 10'd2) begin
			seg.value = (pos == 10'd0) ? 8'hff : 8'hd8;
		end else if (pos < qend) begin
			case (dq_off)
				10'd0: seg.value = 8'hff;
				10'd1: seg.value = 8'hdb;
				10'd2: seg.value = 8'h00;
				10'd3: seg.value = 8'd67;
				10'd4: seg.value = {7'd0, dq_tab};
				default: begin
					seg.is_quant = 1'b1;
					seg.chroma   = dq_tab;
					seg.qidx     = rtpjh_pkg::QIDX_W'(dq_off - 10'd5);
				end
			endcase
		end else if (pos < sof_start) begin
			case (r)
				10'd0: seg.value = 8'hff;
				10'd1: seg.value = 8'hdd;
				10'd2: seg.value = 8'h00;
				10'd3: seg.value = 8'h04;
				10'd4: seg.value = cfg.restart_interval[15:8];
				default: seg.value = cfg.restart_interval[7:0];
			endcase
		end else if (pos < dht_start) begin
			case (s)
				10'd0: seg.value = 8'hff;
				10'd1: seg.value = 8'hc0;
				10'd3: seg.value = 8'd17;
				10'd4: seg.value = 8'd8;
				10'd5: seg.value = {5'd0, hpx[10:8]};
				10'd6: seg.value = hpx[7:0];
				10'd7: seg.value = {5'd0, wpx[10:8]};
				10'd8: seg.value = wpx[7:0];
				10'd9: seg.value = 8'd3;
				10'd11: seg.value = cfg.frame_type ? 8'h22 : 8'h21;
				10'd13: seg.value = 8'd1;
				10'd14: seg.value = 8'h11;
				10'd15: seg.value = qsel;
				10'd16: seg.value = 8'd2;
				10'd17: seg.value = 8'h11;
				10'd18: seg.value = qsel;
				default: seg.value = 8'h00;
			endcase
		end else if (pos < sos_start) begin
			case (o)
				10'd0: seg.value = 8'hff;
				10'd1: seg.value = 8'hc4;
				10'd2: seg.value = 8'h00;
				10'd3: seg.value = ac ? 8'd181 : 8'd31;
				10'd4: seg.value = {3'd0, ac, 3'd0, t[1]};
				default: begin
					if (o < 10'd21) begin
						seg.value = rtpjh_pkg::CODE_COUNTS[{t, 4'(o - 10'd5)}];
					end else if (!ac) begin
						seg.value = sym_idx;
					end else if (t[1]) begin
						seg.value = rtpjh_pkg::AC_SYMS_CHROMA[sym_idx];
					end else begin
						seg.value = rtpjh_pkg::AC_SYMS_LUMA[sym_idx];
					end
				end
			endcase
		end else if (e < 10'd14) begin
			seg.value = rtpjh_pkg::SOS_BYTES[4'(e)];
		end
	end

endmodule

/* rtl/rtp_jpeg_header_generator.sv */
// Top level of the JPEG header generator: configuration registers and byte sequencer.
// Each accepted item yields the next byte of an RFC 2435 style JPEG header (SOI, DQT,
// optional DRI, SOF0, four DHT tables, SOS), with its position and a last flag; a restart
// item begins again at byte zero and the position wraps after the final byte. One item
// is in flight at a time and the input stalls until its byte sits in the output register.
// A fixed byte passes the decode, evaluate and output states before the output register
// loads. A quantiser byte at quality 50 and above adds one multiply for base*scale and one
// reciprocal multiply for the rounding divide by 100. Below 50 the 20-step restoring
// divider first forms 5000/quality. While a full output register is stalled, the byte
// waits in the output state. Configuration writes are taken in any cycle and must only be
// issued while the block is idle.
module rtp_jpeg_header_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            header_byte,
	output logic [rtpjh_pkg::POS_W-1:0]           byte_index,
	output logic                                  last,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rtpjh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rtpjh_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EVAL,
		S_SCALE,
		S_MUL,
		S_DIV,
		S_OUT
	} state_t;

	state_t                               state_q;
	rtpjh_pkg::cfg_t                      cfg_q;
	rtpjh_pkg::seg_t                      seg;
	rtpjh_pkg::seg_t                      seg_q;
	logic [rtpjh_pkg::POS_W-1:0]          byte_pos_q;
	logic [rtpjh_pkg::POS_W-1:0]          item_pos_q;
	logic [rtpjh_pkg::SCALE_W-1:0]        scale_q;
	logic [7:0]                           byte_q;
	logic                                 div_start_q;
	logic [rtpjh_pkg::DIV_NUM_W-1:0]      div_num_q;
	logic [rtpjh_pkg::DIV_DEN_W-1:0]      div_den_q;
	logic                                 div_done;
	logic [rtpjh_pkg::DIV_NUM_W-1:0]      div_quot;
	logic [rtpjh_pkg::DIV_NUM_W-1:0]      prod_q;
	logic                                 out_valid_q;
	logic [7:0]                           header_byte_q;
	logic [rtpjh_pkg::POS_W-1:0]          byte_index_q;
	logic                                 last_q;

	logic [rtpjh_pkg::POS_W-1:0]          len;
	logic [rtpjh_pkg::POS_W-1:0]          start_pos;
	logic [rtpjh_pkg::POS_W-1:0]          pos_inc;
	logic [rtpjh_pkg::DIV_DEN_W-1:0]      fq;
	logic [7:0]                           fq_dbl;
	logic [rtpjh_pkg::BASE_W-1:0]         base;
	logic [rtpjh_pkg::DIV_NUM_W-1:0]      prod;
	logic [rtpjh_pkg::RND_PROD_W-1:0]     rnd_prod;
	logic [rtpjh_pkg::RND_PROD_W-rtpjh_pkg::RND_SHIFT-1:0] rnd_quot;
	logic [7:0]                           qbyte;

	always_comb begin
		len       = rtpjh_pkg::hdr_len(cfg_q);
		start_pos = (restart || (byte_pos_q >= len)) ? '0 : byte_pos_q;
		pos_inc   = item_pos_q + 1'b1;
		if (cfg_q.quality == 8'd0) begin
			fq = 7'd1;
		end else if (cfg_q.quality > 8'd99) begin
			fq = 7'd99;
		end else begin
			fq = cfg_q.quality[rtpjh_pkg::DIV_DEN_W-1:0];
		end
		fq_dbl = {fq, 1'b0};
		base   = seg_q.chroma ? rtpjh_pkg::BASE_CHROMA[seg_q.qidx]
		                      : rtpjh_pkg::BASE_LUMA[seg_q.qidx];
		prod   = {13'd0, base} * {7'd0, scale_q} + 20'd50;
		rnd_prod = {20'd0, prod_q} * {20'd0, rtpjh_pkg::RND_MUL};
		rnd_quot = rnd_prod[rtpjh_pkg::RND_PROD_W-1:rtpjh_pkg::RND_SHIFT];
		if (rnd_quot > 14'd255) begin
			qbyte = 8'hff;
		end else if (rnd_quot == '0) begin
			qbyte = 8'h01;
		end else begin
			qbyte = rnd_quot[7:0];
		end
	end

	rtpjh_seg u_seg (
		.pos (item_pos_q),
		.cfg (cfg_q),
		.seg (seg)
	);

	rtpjh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				quality:               rtpjh_pkg::QUALITY_RESET,
				frame_type:            1'b0,
				width_blocks:          8'd0,
				height_blocks:         8'd0,
				restart_interval:      16'd0,
				separate_chroma_table: 1'b1
			};
		end else if (cfg_valid) begin
			case (cfg_index)
				rtpjh_pkg::REG_QUALITY:    cfg_q.quality <= cfg_data[7:0];
				rtpjh_pkg::REG_FRAME_TYPE: cfg_q.frame_type <= cfg_data[0];
				rtpjh_pkg::REG_WIDTH:      cfg_q.width_blocks <= cfg_data[7:0];
				rtpjh_pkg::REG_HEIGHT:     cfg_q.height_blocks <= cfg_data[7:0];
				rtpjh_pkg::REG_RESTART:    cfg_q.restart_interval <= cfg_data;
				rtpjh_pkg::REG_SEP_CHROMA: cfg_q.separate_chroma_table <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			seg_q         <= '0;
			byte_pos_q    <= '0;
			item_pos_q    <= '0;
			scale_q       <= '0;
			byte_q        <= '0;
			div_start_q   <= 1'b0;
			div_num_q     <= '0;
			div_den_q     <= '0;
			prod_q        <= '0;
			out_valid_q   <= 1'b0;
			header_byte_q <= '0;
			byte_index_q  <= '0;
			last_q        <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_pos_q <= start_pos;
						state_q    <= S_DECODE;
					end
				end
				S_DECODE: begin
					seg_q   <= seg;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!seg_q.is_quant) begin
						byte_q  <= seg_q.value;
						state_q <= S_OUT;
					end else if (fq < 7'd50) begin
						div_start_q <= 1'b1;
						div_num_q   <= rtpjh_pkg::SCALE_NUM;
						div_den_q   <= fq;
						state_q     <= S_SCALE;
					end else begin
						scale_q <= {5'd0, 8'd200 - fq_dbl};
						state_q <= S_MUL;
					end
				end
				S_SCALE: begin
					if (div_done) begin
						scale_q <= div_quot[rtpjh_pkg::SCALE_W-1:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod;
					state_q <= S_DIV;
				end
				S_DIV: begin
					byte_q  <= qbyte;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						header_byte_q <= byte_q;
						byte_index_q  <= item_pos_q;
						last_q        <= (pos_inc == len);
						byte_pos_q    <= (pos_inc >= len) ? '0 : pos_inc;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign header_byte = header_byte_q;
	assign byte_index  = byte_index_q;
	assign last        = last_q;

endmodule

/* tb/sv/tb_hdr_checker.sv */
// Header byte checker: mirrors the configuration, predicts every header byte and compares it.
`timescale 1ns / 100ps
module tb_hdr_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             restart,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [7:0]                       header_byte,
	input  logic [rtpjh_pkg::POS_W-1:0]      byte_index,
	input  logic                             last,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [rtpjh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtpjh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                               mismatches,
	output int                               outstanding
);

	typedef struct packed {
		logic [7:0]                  value;
		logic [rtpjh_pkg::POS_W-1:0] index;
		logic                        last;
	} hdr_beat_t;

	localparam logic [7:0] LUMA_BASE [0:63] = '{
		8'd16, 8'd11, 8'd12, 8'd14, 8'd12, 8'd10, 8'd16, 8'd14,
		8'd13, 8'd14, 8'd18, 8'd17, 8'd16, 8'd19, 8'd24, 8'd40,
		8'd26, 8'd24, 8'd22, 8'd22, 8'd24, 8'd49, 8'd35, 8'd37,
		8'd29, 8'd40, 8'd58, 8'd51, 8'd61, 8'd60, 8'd57, 8'd51,
		8'd56, 8'd55, 8'd64, 8'd72, 8'd92, 8'd78, 8'd64, 8'd68,
		8'd87, 8'd69, 8'd55, 8'd56, 8'd80, 8'd109, 8'd81, 8'd87,
		8'd95, 8'd98, 8'd103, 8'd104, 8'd103, 8'd62, 8'd77, 8'd113,
		8'd121, 8'd112, 8'd100, 8'd120, 8'd92, 8'd101, 8'd103, 8'd99
	};

	localparam logic [7:0] CHROMA_HEAD [0:15] = '{
		8'd17, 8'd18, 8'd18, 8'd24, 8'd21, 8'd24, 8'd47, 8'd26,
		8'd26, 8'd47, 8'd99, 8'd66, 8'd56, 8'd66, 8'd99, 8'd99
	};

	localparam logic [7:0] HUFF_COUNTS [0:63] = '{
		8'h00, 8'h01, 8'h05, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h02, 8'h01, 8'h03, 8'h03, 8'h02, 8'h04, 8'h03,
		8'h05, 8'h05, 8'h04, 8'h04, 8'h00, 8'h00, 8'h01, 8'h7d,
		8'h00, 8'h03, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h02, 8'h01, 8'h02, 8'h04, 8'h04, 8'h03, 8'h04,
		8'h07, 8'h05, 8'h04, 8'h04, 8'h00, 8'h01, 8'h02, 8'h77
	};

	localparam logic [7:0] AC_LUMA [0:161] = '{
		8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41, 8'h06,
		8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
		8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24, 8'h33, 8'h62, 8'h72,
		8'h82, 8'h09, 8'h0a, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
		8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44, 8'h45,
		8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
		8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75,
		8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
		8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3,
		8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
		8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9,
		8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
		8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf1, 8'hf2, 8'hf3, 8'hf4,
		8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
	};

	localparam logic [7:0] AC_CHROMA [0:161] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21, 8'h31, 8'h06, 8'h12, 8'h41,
		8'h51, 8'h07, 8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
		8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0, 8'h15, 8'h62, 8'h72, 8'hd1,
		8'h0a, 8'h16, 8'h24, 8'h34, 8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
		8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44,
		8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
		8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74,
		8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
		8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
		8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
		8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
		8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf2, 8'hf3, 8'hf4,
		8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
	};

	localparam logic [7:0] SCAN_HEADER [0:13] = '{
		8'hff, 8'hda, 8'h00, 8'h0c, 8'h03, 8'h00, 8'h00,
		8'h01, 8'h11, 8'h02, 8'h11, 8'h00, 8'h3f, 8'h00
	};

	rtpjh_pkg::cfg_t             shadow;
	logic [rtpjh_pkg::POS_W-1:0] next_pos;
	hdr_beat_t                   expected_beats [$];
	hdr_beat_t                   want;
	hdr_beat_t                   got;
	int                          len;
	int                          pos;

	function automatic int quant_entry(input int base);
		int f;
		int s;
		int v;
		f = shadow.quality;
		if (f < 1) f = 1;
		if (f > 99) f = 99;
		s = (f < 50) ? 5000 / f : 200 - 2 * f;
		v = (base * s + 50) / 100;
		if (v < 1) v = 1;
		if (v > 255) v = 255;
		return v;
	endfunction

	function automatic int header_len();
		return 2 + (shadow.separate_chroma_table ? 138 : 69) +
			(shadow.restart_interval != 16'd0 ? 6 : 0) + 465;
	endfunction

	function automatic logic [7:0] jpeg_header_byte(input int p);
		int q;
		int t;
		int n;
		int seg;
		int base;
		logic [15:0] hpx;
		logic [15:0] wpx;
		if (p == 0) return 8'hff;
		if (p == 1) return 8'hd8;
		q = p - 2;
		n = shadow.separate_chroma_table ? 2 : 1;
		if (q < 69 * n) begin
			t = q / 69;
			q = q % 69;
			case (q)
			0: return 8'hff;
			1: return 8'hdb;
			2: return 8'h00;
			3: return 8'd67;
			4: return t[7:0];
			default: begin
				if (t == 0) base = LUMA_BASE[q - 5];
				else base = (q - 5 < 16) ? CHROMA_HEAD[q - 5] : 99;
				return 8'(quant_entry(base));
			end
			endcase
		end
		q = q - 69 * n;
		if (shadow.restart_interval != 16'd0) begin
			case (q)
			0: return 8'hff;
			1: return 8'hdd;
			2: return 8'h00;
			3: return 8'h04;
			4: return shadow.restart_interval[15:8];
			5: return shadow.restart_interval[7:0];
			default: ;
			endcase
			q = q - 6;
		end
		hpx = {5'b0, shadow.height_blocks, 3'b0};
		wpx = {5'b0, shadow.width_blocks, 3'b0};
		if (q < 19) begin
			case (q)
			0: return 8'hff;
			1: return 8'hc0;
			2: return 8'h00;
			3: return 8'd17;
			4: return 8'd8;
			5: return hpx[15:8];
			6: return hpx[7:0];
			7: return wpx[15:8];
			8: return wpx[7:0];
			9: return 8'd3;
			10: return 8'd0;
			11: return shadow.frame_type ? 8'h22 : 8'h21;
			12: return 8'd0;
			13: return 8'd1;
			14: return 8'h11;
			15: return {7'b0, shadow.separate_chroma_table};
			16: return 8'd2;
			17: return 8'h11;
			default: return {7'b0, shadow.separate_chroma_table};
			endcase
		end
		q = q - 19;
		for (t = 0; t < 4; t++) begin
			seg = t[0] ? 183 : 33;
			if (q < seg) begin
				case (q)
				0: return 8'hff;
				1: return 8'hc4;
				2: return 8'h00;
				3: return 8'(seg - 2);
				4: return {3'b000, t[0], 3'b000, t[1]};
				default: ;
				endcase
				if (q < 21) return HUFF_COUNTS[t * 16 + q - 5];
				q = q - 21;
				if (!t[0]) return 8'(q);
				return t[1] ? AC_CHROMA[q] : AC_LUMA[q];
			end
			q = q - seg;
		end
		if (q < 14) return SCAN_HEADER[q];
		return 8'h00;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			shadow.quality = rtpjh_pkg::QUALITY_RESET;
			shadow.frame_type = 1'b0;
			shadow.width_blocks = 8'd0;
			shadow.height_blocks = 8'd0;
			shadow.restart_interval = 16'd0;
			shadow.separate_chroma_table = 1'b1;
			next_pos = '0;
			expected_beats.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				rtpjh_pkg::REG_QUALITY:    shadow.quality = cfg_data[7:0];
				rtpjh_pkg::REG_FRAME_TYPE: shadow.frame_type = cfg_data[0];
				rtpjh_pkg::REG_WIDTH:      shadow.width_blocks = cfg_data[7:0];
				rtpjh_pkg::REG_HEIGHT:     shadow.height_blocks = cfg_data[7:0];
				rtpjh_pkg::REG_RESTART:    shadow.restart_interval = cfg_data[15:0];
				rtpjh_pkg::REG_SEP_CHROMA: shadow.separate_chroma_table = cfg_data[0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				len = header_len();
				pos = restart ? 0 : int'(next_pos);
				if (pos >= len) pos = 0;
				want.value = jpeg_header_byte(pos);
				want.index = pos[rtpjh_pkg::POS_W-1:0];
				want.last = (pos + 1 == len);
				next_pos = (pos + 1 >= len) ? '0 : pos[rtpjh_pkg::POS_W-1:0] + 1'b1;
				expected_beats.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got.value = header_byte;
				got.index = byte_index;
				got.last = last;
				if (expected_beats.size() == 0) begin
					if (mismatches < 10)
						$display("extra header byte %02h at index %0d last %0b",
							got.value, got.index, got.last);
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					if (got.value !== want.value || got.index !== want.index ||
						got.last !== want.last) begin
						if (mismatches < 10)
							$display("byte at %0t: exp %02h/%0d/%0b got %02h/%0d/%0b",
								$realtime, want.value, want.index, want.last,
								got.value, got.index, got.last);
						mismatches++;
					end
				end
			end
			outstanding = expected_beats.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Bench top for the JPEG header generator: clock, reset, item and register stimulus, verdict.
`timescale 1ns / 100ps
module tb_top;

	localparam int ITEM_TARGET   = 1950;
	localparam int SETTLE_CYCLES = 60;
	localparam int IDLE_LIMIT    = 4000;
	localparam logic [rtpjh_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [rtpjh_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic                             restart   = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [7:0]                       header_byte;
	logic [rtpjh_pkg::POS_W-1:0]      byte_index;
	logic                             last;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [rtpjh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rtpjh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	int                               mismatches;
	int                               outstanding;
	int                               items_sent  = 0;
	int                               burst_left  = 0;
	int                               stall_left  = 0;
	int                               stall_mode  = 0;
	int                               idle_cycles = 0;

	rtp_jpeg_header_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.header_byte (header_byte),
		.byte_index  (byte_index),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	tb_hdr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.header_byte (header_byte),
		.byte_index  (byte_index),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 3) == 0);
		2: out_stall <= ($urandom_range(0, 1) == 0);
		default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [rtpjh_pkg::CFG_IDX_W-1:0] idx,
		input logic [rtpjh_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic release_cfg;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_item(input logic restart_bit);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		restart <= restart_bit;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// hold off until every expected byte is back, then let the block settle
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [rtpjh_pkg::CFG_DATA_W-1:0] cfg_pick(
		input logic [rtpjh_pkg::CFG_IDX_W-1:0] idx);
		logic [rtpjh_pkg::CFG_DATA_W-1:0] v;
		v = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
		0: v = '0;
		1: v = '1;
		2: begin
			if (idx == rtpjh_pkg::REG_QUALITY) begin
				case ($urandom_range(0, 4))
				0: v = 16'd1;
				1: v = 16'd49;
				2: v = 16'd50;
				3: v = 16'd99;
				default: v = 16'd100;
				endcase
			end
		end
		default: begin
			if (idx == rtpjh_pkg::REG_QUALITY) v[7:0] = 8'($urandom_range(1, 110));
		end
		endcase
		return v;
	endfunction

	task automatic random_phase;
		int n;
		int r;
		for (r = 0; r < 8; r++) begin
			if ($urandom_range(0, 1) == 1)
				write_reg(r[rtpjh_pkg::CFG_IDX_W-1:0], cfg_pick(r[rtpjh_pkg::CFG_IDX_W-1:0]));
		end
		release_cfg();
		n = $urandom_range(20, 200);
		if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
		push_item($urandom_range(0, 3) != 0);
		repeat (n - 1) push_item($urandom_range(0, 149) == 0);
		drain();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		repeat (7) push_item(1'b0);
		drain();

		// quality clamps at both ends, spare indexes ignored
		write_reg(REG_SPARE_A, 16'hffff);
		write_reg(REG_SPARE_B, 16'h5a5a);
		write_reg(rtpjh_pkg::REG_QUALITY, 16'h0000);
		release_cfg();
		push_item(1'b1);
		repeat (5) push_item(1'b0);
		drain();
		write_reg(rtpjh_pkg::REG_QUALITY, 16'hffff);
		release_cfg();
		push_item(1'b1);
		repeat (5) push_item(1'b0);
		drain();

		// longest header, walked through its last byte and wrapped
		write_reg(rtpjh_pkg::REG_QUALITY, 16'd1);
		write_reg(rtpjh_pkg::REG_FRAME_TYPE, 16'hffff);
		write_reg(rtpjh_pkg::REG_WIDTH, 16'h00ff);
		write_reg(rtpjh_pkg::REG_HEIGHT, 16'hff80);
		write_reg(rtpjh_pkg::REG_RESTART, 16'hffff);
		write_reg(rtpjh_pkg::REG_SEP_CHROMA, 16'h0001);
		release_cfg();
		push_item(1'b1);
		repeat (620) push_item(1'b0);
		drain();

		// stop near the end, then shorten the header under the position
		write_reg(rtpjh_pkg::REG_QUALITY, 16'd99);
		write_reg(rtpjh_pkg::REG_FRAME_TYPE, 16'h0000);
		write_reg(rtpjh_pkg::REG_WIDTH, 16'h0000);
		write_reg(rtpjh_pkg::REG_HEIGHT, 16'h0001);
		write_reg(rtpjh_pkg::REG_RESTART, 16'h0000);
		release_cfg();
		push_item(1'b1);
		repeat (599) push_item(1'b0);
		drain();
		write_reg(rtpjh_pkg::REG_SEP_CHROMA, 16'hfffe);
		release_cfg();
		repeat (10) push_item(1'b0);
		drain();

		while (items_sent < ITEM_TARGET) random_phase();

		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* rtp_jpeg_header_generator.f */
rtl/rtpjh_pkg.sv
rtl/rtpjh_div.sv
rtl/rtpjh_seg.sv
rtl/rtp_jpeg_header_generator.sv
tb/sv/tb_hdr_checker.sv
tb/sv/tb_top.sv
